// ----- sv/plle_pkg.sv -----
// ---------------------------------------------------------------------------
// plle_pkg: shared types and codes for the pooled linked list engine
// Transaction payloads, operation and status codes, controller states.
// ---------------------------------------------------------------------------
`default_nettype none

package plle_pkg;

    localparam int KEY_W  = 16;
    localparam int DATA_W = 64;
    localparam int LEN_W  = 8;
    localparam int MODE_W = 3;
    localparam int STAT_W = 3;
    localparam int CNT_W  = 5;

    localparam logic [MODE_W-1:0] MODE_INSERT    = 3'd0;
    localparam logic [MODE_W-1:0] MODE_REMOVE    = 3'd1;
    localparam logic [MODE_W-1:0] MODE_FIND      = 3'd2;
    localparam logic [MODE_W-1:0] MODE_FIND_NEXT = 3'd3;
    localparam logic [MODE_W-1:0] MODE_FIND_PREV = 3'd4;

    localparam logic [STAT_W-1:0] ST_OK      = 3'd0;
    localparam logic [STAT_W-1:0] ST_FULL    = 3'd1;
    localparam logic [STAT_W-1:0] ST_NOSLOT  = 3'd2;
    localparam logic [STAT_W-1:0] ST_NOKEY   = 3'd3;
    localparam logic [STAT_W-1:0] ST_NONEIGH = 3'd4;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [KEY_W-1:0]  key;
        logic [DATA_W-1:0] payload;
        logic [LEN_W-1:0]  payload_len;
    } t_in;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [DATA_W-1:0] read_data;
        logic [CNT_W-1:0]  entry_count;
    } t_out;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INS1,
        S_INS2,
        S_WALK,
        S_RM1,
        S_RM2,
        S_RM3,
        S_RM4,
        S_DATA,
        S_RESP
    } t_state;

endpackage

`default_nettype wire

// ----- sv/plle_ram.sv -----
// ---------------------------------------------------------------------------
// plle_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ---------------------------------------------------------------------------
`default_nettype none

module plle_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ----- sv/pooled_linked_list_engine_unit.sv -----
// ---------------------------------------------------------------------------
// pooled_linked_list_engine_unit: doubly linked list over a fixed slot pool
// Insert appends the lowest free slot at the tail; remove/find walk from
// the head to the first key match. Links and data live in two RAMs.
// ---------------------------------------------------------------------------
//  channel | direction | handshake                   | payload
//  in      | input     | i_in_valid / o_in_stall     | i_in_data  (t_in)
//  out     | output    | o_out_valid / i_out_stall   | o_out_data (t_out)
//
//  Searches walk the list from the head through a link RAM read loop and
//  visit at most SLOTS nodes; a remove then relinks both neighbors.
//  One transaction is in work at a time.
//  The output register holds a result while i_out_stall is high; the next
//  transaction is accepted meanwhile. Reset empties the list at once.
// ---------------------------------------------------------------------------
`default_nettype none

module pooled_linked_list_engine_unit #(
    parameter int SLOTS         = 16,
    parameter int ELEMENT_BYTES = 8
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_stall,
    input  wire plle_pkg::t_in    i_in_data,
    output logic                  o_out_valid,
    input  wire logic             i_out_stall,
    output plle_pkg::t_out        o_out_data
);

    localparam int IW  = $clog2(SLOTS);
    localparam int PW  = IW + 1;
    localparam int CW  = $clog2(SLOTS + 1);
    localparam int DW  = 8 * ELEMENT_BYTES;
    localparam int KW  = plle_pkg::KEY_W;
    localparam int LW  = KW + 2 * PW;
    localparam logic [PW-1:0] NIL = PW'(SLOTS);

    plle_pkg::t_state r_state, n_state;

    logic [plle_pkg::MODE_W-1:0] r_mode, n_mode;
    logic [KW-1:0]               r_key, n_key;
    logic [DW-1:0]               r_payload, n_payload;
    logic [plle_pkg::LEN_W-1:0]  r_len, n_len;
    logic [PW-1:0]               r_cur, n_cur, r_p, n_p, r_nx, n_nx;
    logic [PW-1:0]               r_head, n_head, r_tail, n_tail;
    logic [CW-1:0]               r_steps, n_steps, r_count, n_count;
    logic [SLOTS-1:0]            r_used, n_used;
    logic [IW-1:0]               r_free, n_free;
    logic [plle_pkg::STAT_W-1:0] r_status, n_status;
    logic [plle_pkg::DATA_W-1:0] r_rd, n_rd;
    logic                        r_out_valid, n_out_valid;
    plle_pkg::t_out              r_out, n_out;

    logic          l_we, l_re, d_we, d_re;
    logic [IW-1:0] l_waddr, l_raddr, d_waddr, d_raddr;
    logic [LW-1:0] l_wdata, l_rdata;
    logic [DW-1:0] d_wdata, d_rdata, byte_mask;

    logic          free_found;
    logic [IW-1:0] free_idx;

    logic [KW-1:0] rd_key;
    logic [PW-1:0] rd_next, rd_prev;

    assign rd_key  = l_rdata[LW-1 -: KW];
    assign rd_next = l_rdata[2*PW-1:PW];
    assign rd_prev = l_rdata[PW-1:0];

    plle_ram #(.WIDTH(LW), .DEPTH(SLOTS)) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (l_we),
        .i_waddr (l_waddr),
        .i_wdata (l_wdata),
        .i_re    (l_re),
        .i_raddr (l_raddr),
        .o_rdata (l_rdata)
    );

    plle_ram #(.WIDTH(DW), .DEPTH(SLOTS)) u_data_ram (
        .i_clk   (i_clk),
        .i_we    (d_we),
        .i_waddr (d_waddr),
        .i_wdata (d_wdata),
        .i_re    (d_re),
        .i_raddr (d_raddr),
        .o_rdata (d_rdata)
    );

    // lowest unused slot
    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (!r_used[i]) begin
                free_found = 1'b1;
                free_idx   = IW'(i);
            end
        end
    end

    always_comb begin
        for (int b = 0; b < ELEMENT_BYTES; b++) begin
            byte_mask[8*b +: 8] = (plle_pkg::LEN_W'(b) < r_len) ? 8'hFF : 8'h00;
        end
    end

    assign o_in_stall  = (r_state != plle_pkg::S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= plle_pkg::S_IDLE;
            r_head      <= NIL;
            r_tail      <= NIL;
            r_count     <= '0;
            r_used      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_count     <= n_count;
            r_used      <= n_used;
            r_out_valid <= n_out_valid;
        end
        r_mode    <= n_mode;
        r_key     <= n_key;
        r_payload <= n_payload;
        r_len     <= n_len;
        r_cur     <= n_cur;
        r_p       <= n_p;
        r_nx      <= n_nx;
        r_steps   <= n_steps;
        r_free    <= n_free;
        r_status  <= n_status;
        r_rd      <= n_rd;
        r_out     <= n_out;
    end

    always_comb begin
        n_state     = r_state;
        n_mode      = r_mode;
        n_key       = r_key;
        n_payload   = r_payload;
        n_len       = r_len;
        n_cur       = r_cur;
        n_p         = r_p;
        n_nx        = r_nx;
        n_head      = r_head;
        n_tail      = r_tail;
        n_steps     = r_steps;
        n_count     = r_count;
        n_used      = r_used;
        n_free      = r_free;
        n_status    = r_status;
        n_rd        = r_rd;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;

        l_we    = 1'b0;
        l_waddr = '0;
        l_wdata = '0;
        l_re    = 1'b0;
        l_raddr = '0;
        d_we    = 1'b0;
        d_waddr = '0;
        d_wdata = '0;
        d_re    = 1'b0;
        d_raddr = '0;

        unique case (r_state)
            plle_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_mode    = i_in_data.mode;
                    n_key     = i_in_data.key;
                    n_payload = i_in_data.payload[DW-1:0];
                    n_len     = i_in_data.payload_len;
                    n_rd      = '0;
                    n_status  = plle_pkg::ST_OK;
                    n_state   = plle_pkg::S_RESP;
                    case (i_in_data.mode)
                        plle_pkg::MODE_INSERT: begin
                            if (r_count >= CW'(SLOTS)) begin
                                n_status = plle_pkg::ST_FULL;
                            end else if (!free_found) begin
                                n_status = plle_pkg::ST_NOSLOT;
                            end else begin
                                n_free  = free_idx;
                                d_re    = 1'b1;
                                d_raddr = free_idx;
                                l_re    = (r_tail != NIL);
                                l_raddr = r_tail[IW-1:0];
                                n_state = plle_pkg::S_INS1;
                            end
                        end
                        plle_pkg::MODE_REMOVE, plle_pkg::MODE_FIND,
                        plle_pkg::MODE_FIND_NEXT, plle_pkg::MODE_FIND_PREV: begin
                            if (r_head == NIL) begin
                                n_status = plle_pkg::ST_NOKEY;
                            end else begin
                                l_re    = 1'b1;
                                l_raddr = r_head[IW-1:0];
                                n_cur   = r_head;
                                n_steps = '0;
                                n_state = plle_pkg::S_WALK;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            plle_pkg::S_INS1: begin
                d_we    = 1'b1;
                d_waddr = r_free;
                d_wdata = (d_rdata & ~byte_mask) | (r_payload & byte_mask);
                l_we    = 1'b1;
                l_waddr = r_free;
                l_wdata = {r_key, NIL, r_tail};
                n_used[r_free] = 1'b1;
                if (r_tail != NIL) begin
                    n_state = plle_pkg::S_INS2;
                end else begin
                    n_head  = PW'(r_free);
                    n_tail  = PW'(r_free);
                    n_count = r_count + 1'b1;
                    n_state = plle_pkg::S_RESP;
                end
            end
            plle_pkg::S_INS2: begin
                // old tail still sits in the link read register
                l_we    = 1'b1;
                l_waddr = r_tail[IW-1:0];
                l_wdata = {rd_key, PW'(r_free), rd_prev};
                n_tail  = PW'(r_free);
                n_count = r_count + 1'b1;
                n_state = plle_pkg::S_RESP;
            end
            plle_pkg::S_WALK: begin
                if (rd_key == r_key) begin
                    n_p     = rd_prev;
                    n_nx    = rd_next;
                    n_state = plle_pkg::S_DATA;
                    case (r_mode)
                        plle_pkg::MODE_REMOVE: begin
                            n_state = plle_pkg::S_RM1;
                        end
                        plle_pkg::MODE_FIND_NEXT: begin
                            if (rd_next == NIL) begin
                                n_status = plle_pkg::ST_NONEIGH;
                                n_state  = plle_pkg::S_RESP;
                            end else begin
                                d_re    = 1'b1;
                                d_raddr = rd_next[IW-1:0];
                            end
                        end
                        plle_pkg::MODE_FIND_PREV: begin
                            if (rd_prev == NIL) begin
                                n_status = plle_pkg::ST_NONEIGH;
                                n_state  = plle_pkg::S_RESP;
                            end else begin
                                d_re    = 1'b1;
                                d_raddr = rd_prev[IW-1:0];
                            end
                        end
                        default: begin
                            d_re    = 1'b1;
                            d_raddr = r_cur[IW-1:0];
                        end
                    endcase
                end else if (rd_next == NIL || r_steps == CW'(SLOTS - 1)) begin
                    n_status = plle_pkg::ST_NOKEY;
                    n_state  = plle_pkg::S_RESP;
                end else begin
                    l_re    = 1'b1;
                    l_raddr = rd_next[IW-1:0];
                    n_cur   = rd_next;
                    n_steps = r_steps + 1'b1;
                end
            end
            plle_pkg::S_RM1: begin
                n_used[r_cur[IW-1:0]] = 1'b0;
                n_count = r_count - 1'b1;
                if (r_p != NIL) begin
                    l_re    = 1'b1;
                    l_raddr = r_p[IW-1:0];
                    n_state = plle_pkg::S_RM2;
                end else begin
                    n_head  = r_nx;
                    n_state = plle_pkg::S_RM3;
                end
            end
            plle_pkg::S_RM2: begin
                l_we    = 1'b1;
                l_waddr = r_p[IW-1:0];
                l_wdata = {rd_key, r_nx, rd_prev};
                n_state = plle_pkg::S_RM3;
            end
            plle_pkg::S_RM3: begin
                if (r_nx != NIL) begin
                    l_re    = 1'b1;
                    l_raddr = r_nx[IW-1:0];
                    n_state = plle_pkg::S_RM4;
                end else begin
                    n_tail  = r_p;
                    n_state = plle_pkg::S_RESP;
                end
            end
            plle_pkg::S_RM4: begin
                l_we    = 1'b1;
                l_waddr = r_nx[IW-1:0];
                l_wdata = {rd_key, rd_next, r_p};
                n_state = plle_pkg::S_RESP;
            end
            plle_pkg::S_DATA: begin
                n_rd    = plle_pkg::DATA_W'(d_rdata);
                n_state = plle_pkg::S_RESP;
            end
            plle_pkg::S_RESP: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out.status      = r_status;
                    n_out.read_data   = r_rd;
                    n_out.entry_count = plle_pkg::CNT_W'(r_count);
                    n_out_valid       = 1'b1;
                    n_state           = plle_pkg::S_IDLE;
                end
            end
            default: n_state = plle_pkg::S_IDLE;
        endcase
    end

endmodule

`default_nettype wire
